// ----- src/assert_macros.svh -----
// Concurrent check helpers; expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHECK_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`define CHECK_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/aigsim_pkg.sv -----
`default_nettype none

package aigsim_pkg;

    localparam int LIT_W       = 13;
    localparam int VAR_W       = 12;
    localparam int INDEX_W     = 12;
    localparam int PORT_WORD_W = 64;
    localparam int RECIP_SHIFT = 24;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        KIND_INPUT  = 2'd0,
        KIND_AND    = 2'd1,
        KIND_OUTPUT = 2'd2
    } aigsim_kind_t;

    typedef struct packed {
        aigsim_kind_t kind;
        logic         comp0;
        logic         comp1;
        logic         zero0;
        logic         zero1;
        logic         last;
    } aigsim_ctl_t;

endpackage

`default_nettype wire

// ----- src/aigsim_front.sv -----
`default_nettype none
`include "assert_macros.svh"

module aigsim_front
    import aigsim_pkg::*;
#(
    parameter int MAX_OBJECTS = 4096,
    parameter int SIM_BITS    = 64
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [LIT_W-1:0]               fanin0_literal,
    input  wire logic [LIT_W-1:0]               fanin1_literal,
    input  wire logic [PORT_WORD_W-1:0]         pattern_word,
    input  wire logic                           last_in_round,
    output logic                                push_valid,
    input  wire logic                           push_full,
    output aigsim_ctl_t                         push_ctl,
    output logic [$clog2(MAX_OBJECTS)-1:0]      push_idx,
    output logic [$clog2(MAX_OBJECTS)-1:0]      push_var0,
    output logic [$clog2(MAX_OBJECTS)-1:0]      push_var1,
    output logic [SIM_BITS-1:0]                 push_pattern
);

    localparam int IDX_W  = $clog2(MAX_OBJECTS);
    localparam int PROD_W = VAR_W + RECIP_SHIFT;
    localparam logic [PROD_W-1:0] RECIP  = PROD_W'((1 << RECIP_SHIFT) / MAX_OBJECTS);
    localparam logic [31:0]       MAX_L  = 32'(MAX_OBJECTS);
    localparam logic [IDX_W-1:0]  ONE    = IDX_W'(1);
    localparam logic [IDX_W-1:0]  TOP_IX = IDX_W'(MAX_OBJECTS - 1);

    logic                  f_valid_reg;
    logic [IDX_W-1:0]      next_obj_reg;
    logic [IDX_W-1:0]      next_obj_next;
    logic [IDX_W-1:0]      f_idx_reg;
    aigsim_kind_t          f_kind_reg;
    logic                  f_c0_reg;
    logic                  f_c1_reg;
    logic                  f_last_reg;
    logic [VAR_W-1:0]      f_v0_reg;
    logic [VAR_W-1:0]      f_v1_reg;
    logic [VAR_W-1:0]      f_q0_reg;
    logic [VAR_W-1:0]      f_q1_reg;
    logic [SIM_BITS-1:0]   f_pat_reg;

    logic                  accept;
    logic                  f_load;
    aigsim_kind_t          kind_c;
    logic [PROD_W-1:0]     prod0;
    logic [PROD_W-1:0]     prod1;
    logic [31:0]           rem0;
    logic [31:0]           rem1;
    logic [31:0]           red0;
    logic [31:0]           red1;

    assign in_stall = f_valid_reg && push_full;
    assign accept   = in_valid && !in_stall;
    assign f_load   = !f_valid_reg || !push_full;

    // Quotient estimate by reciprocal; corrected below after the register.
    assign prod0 = PROD_W'(fanin0_literal[LIT_W-1:1]) * RECIP;
    assign prod1 = PROD_W'(fanin1_literal[LIT_W-1:1]) * RECIP;

    always_comb
    begin
        if (fanin0_literal == '0)
        begin
            kind_c = KIND_INPUT;
        end
        else if (fanin1_literal == '0)
        begin
            kind_c = KIND_OUTPUT;
        end
        else
        begin
            kind_c = KIND_AND;
        end
    end

    always_comb
    begin
        if (last_in_round || next_obj_reg == TOP_IX)
        begin
            next_obj_next = ONE;
        end
        else
        begin
            next_obj_next = next_obj_reg + ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg  <= 1'b0;
            next_obj_reg <= ONE;
        end
        else
        begin
            if (f_load)
            begin
                f_valid_reg <= accept;
            end
            if (accept)
            begin
                next_obj_reg <= next_obj_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_idx_reg  <= next_obj_reg;
            f_kind_reg <= kind_c;
            f_c0_reg   <= fanin0_literal[0];
            f_c1_reg   <= fanin1_literal[0];
            f_last_reg <= last_in_round;
            f_v0_reg   <= fanin0_literal[LIT_W-1:1];
            f_v1_reg   <= fanin1_literal[LIT_W-1:1];
            f_q0_reg   <= prod0[PROD_W-1 -: VAR_W];
            f_q1_reg   <= prod1[PROD_W-1 -: VAR_W];
            f_pat_reg  <= pattern_word[SIM_BITS-1:0];
        end
    end

    assign rem0 = 32'(f_v0_reg) - 32'(f_q0_reg) * MAX_L;
    assign rem1 = 32'(f_v1_reg) - 32'(f_q1_reg) * MAX_L;
    assign red0 = (rem0 >= MAX_L) ? rem0 - MAX_L : rem0;
    assign red1 = (rem1 >= MAX_L) ? rem1 - MAX_L : rem1;

    assign push_valid     = f_valid_reg && !push_full;
    assign push_idx       = f_idx_reg;
    assign push_var0      = red0[IDX_W-1:0];
    assign push_var1      = red1[IDX_W-1:0];
    assign push_pattern   = f_pat_reg;
    assign push_ctl.kind  = f_kind_reg;
    assign push_ctl.comp0 = f_c0_reg;
    assign push_ctl.comp1 = f_c1_reg;
    assign push_ctl.zero0 = (red0 == '0);
    assign push_ctl.zero1 = (red1 == '0);
    assign push_ctl.last  = f_last_reg;

    `CHECK_IMPLY(f_idx_nonzero, f_valid_reg, f_idx_reg != '0, "object index zero")

endmodule

`default_nettype wire

// ----- src/aigsim_queue.sv -----
`default_nettype none
`include "assert_macros.svh"

module aigsim_queue
    import aigsim_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int CNT_W = QPTR_W + 1;

    logic [WIDTH-1:0]  entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop       = pop_valid && pop_ready;
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push_valid && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!push_valid && pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push_valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `CHECK_NEVER(q_no_overflow, push_valid && full, "request pushed into full queue")

endmodule

`default_nettype wire

// ----- src/aigsim_back.sv -----
`default_nettype none
`include "assert_macros.svh"

module aigsim_back
    import aigsim_pkg::*;
#(
    parameter int MAX_OBJECTS = 4096,
    parameter int SIM_BITS    = 64
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    input  wire logic                           cfg_data,
    input  wire logic                           pop_valid,
    output logic                                pop_ready,
    input  wire aigsim_ctl_t                    pop_ctl,
    input  wire logic [$clog2(MAX_OBJECTS)-1:0] pop_idx,
    input  wire logic [$clog2(MAX_OBJECTS)-1:0] pop_var0,
    input  wire logic [$clog2(MAX_OBJECTS)-1:0] pop_var1,
    input  wire logic [SIM_BITS-1:0]            pop_pattern,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [$clog2(MAX_OBJECTS)-1:0]      o_idx,
    output logic [SIM_BITS-1:0]                 o_value,
    output logic                                o_failed,
    output logic                                o_last
);

    localparam int IDX_W = $clog2(MAX_OBJECTS);

    logic [SIM_BITS-1:0] mem [MAX_OBJECTS];

    logic                miter_reg;
    logic                round_failed_reg;
    logic                a_valid_reg;
    aigsim_ctl_t         a_ctl_reg;
    logic [IDX_W-1:0]    a_idx_reg;
    logic [SIM_BITS-1:0] a_pat_reg;
    logic [SIM_BITS-1:0] rd0_reg;
    logic [SIM_BITS-1:0] rd1_reg;
    logic [SIM_BITS-1:0] fwd0_reg;
    logic [SIM_BITS-1:0] fwd1_reg;
    logic                fsel0_reg;
    logic                fsel1_reg;
    logic                o_valid_reg;
    logic [IDX_W-1:0]    o_idx_reg;
    logic [SIM_BITS-1:0] o_value_reg;
    logic                o_failed_reg;
    logic                o_last_reg;

    logic                a_adv;
    logic                pop;
    logic [SIM_BITS-1:0] w0;
    logic [SIM_BITS-1:0] w1;
    logic [SIM_BITS-1:0] inv0;
    logic [SIM_BITS-1:0] inv1;
    logic [SIM_BITS-1:0] a_value;
    logic                fail_c;

    assign a_adv     = a_valid_reg && (!o_valid_reg || !out_stall);
    assign pop_ready = !a_valid_reg || a_adv;
    assign pop       = pop_valid && pop_ready;

    assign w0   = a_ctl_reg.zero0 ? '0 : (fsel0_reg ? fwd0_reg : rd0_reg);
    assign w1   = a_ctl_reg.zero1 ? '0 : (fsel1_reg ? fwd1_reg : rd1_reg);
    assign inv0 = a_ctl_reg.comp0 ? ~w0 : w0;
    assign inv1 = a_ctl_reg.comp1 ? ~w1 : w1;

    always_comb
    begin
        fail_c = 1'b0;
        case (a_ctl_reg.kind)
            KIND_INPUT:
            begin
                a_value = a_pat_reg;
            end
            KIND_OUTPUT:
            begin
                a_value = w0;
                fail_c  = miter_reg && !round_failed_reg && (inv0 != '0);
            end
            KIND_AND:
            begin
                a_value = inv0 & inv1;
            end
            default:
            begin
                a_value = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            mem[a_idx_reg] <= a_value;
        end
        if (pop)
        begin
            rd0_reg <= mem[pop_var0];
            rd1_reg <= mem[pop_var1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            miter_reg        <= 1'b0;
            round_failed_reg <= 1'b0;
            a_valid_reg      <= 1'b0;
            o_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                miter_reg <= cfg_data;
            end
            if (pop_ready)
            begin
                a_valid_reg <= pop_valid;
            end
            if (a_adv)
            begin
                o_valid_reg <= 1'b1;
                if (a_ctl_reg.last)
                begin
                    round_failed_reg <= 1'b0;
                end
                else if (fail_c)
                begin
                    round_failed_reg <= 1'b1;
                end
            end
            else if (!out_stall)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    // Bypass the word being written this cycle to the read issued alongside it.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_ctl_reg <= pop_ctl;
            a_idx_reg <= pop_idx;
            a_pat_reg <= pop_pattern;
            fwd0_reg  <= a_value;
            fwd1_reg  <= a_value;
            fsel0_reg <= a_adv && (pop_var0 == a_idx_reg);
            fsel1_reg <= a_adv && (pop_var1 == a_idx_reg);
        end
        if (a_adv)
        begin
            o_idx_reg    <= a_idx_reg;
            o_value_reg  <= a_value;
            o_failed_reg <= fail_c;
            o_last_reg   <= a_ctl_reg.last;
        end
    end

    assign out_valid = o_valid_reg;
    assign o_idx     = o_idx_reg;
    assign o_value   = o_value_reg;
    assign o_failed  = o_failed_reg;
    assign o_last    = o_last_reg;

    `CHECK_NEXT(b_fail_sticks, a_adv && fail_c && !a_ctl_reg.last, round_failed_reg,
        "round failure not held")
    `CHECK_IMPLY(b_write_nonzero, a_adv, a_idx_reg != '0, "write to reserved entry zero")

endmodule

`default_nettype wire

// ----- src/aig_bit_parallel_simulator.sv -----
// A request passes the front register, the queue, the operand read register and the output register.
// Throughput: one request per cycle when not stalled; the value store has two read ports and one write port,
// with a bypass for a write one object ahead.
// Reset: asynchronous, active low; clears handshake state, index counter (to 1), fail flag
// and miter mode. The value store is not cleared and needs no clearing pass.
`default_nettype none

module aig_bit_parallel_simulator
    import aigsim_pkg::*;
#(
    parameter int MAX_OBJECTS = 4096,
    parameter int SIM_BITS    = 64
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic                   cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [LIT_W-1:0]       fanin0_literal,
    input  wire logic [LIT_W-1:0]       fanin1_literal,
    input  wire logic [PORT_WORD_W-1:0] pattern_word,
    input  wire logic                   last_in_round,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [INDEX_W-1:0]          object_index,
    output logic [PORT_WORD_W-1:0]      node_value,
    output logic                        output_failed,
    output logic                        round_end
);

    localparam int IDX_W = $clog2(MAX_OBJECTS);
    localparam int CTL_W = $bits(aigsim_ctl_t);
    localparam int QW    = CTL_W + 3 * IDX_W + SIM_BITS;

    logic                push_valid;
    logic                push_full;
    aigsim_ctl_t         push_ctl;
    logic [IDX_W-1:0]    push_idx;
    logic [IDX_W-1:0]    push_var0;
    logic [IDX_W-1:0]    push_var1;
    logic [SIM_BITS-1:0] push_pattern;
    logic [QW-1:0]       push_data;
    logic                pop_valid;
    logic                pop_ready;
    logic [QW-1:0]       pop_data;
    aigsim_ctl_t         pop_ctl;
    logic [IDX_W-1:0]    pop_idx;
    logic [IDX_W-1:0]    pop_var0;
    logic [IDX_W-1:0]    pop_var1;
    logic [SIM_BITS-1:0] pop_pattern;
    logic [IDX_W-1:0]    o_idx;
    logic [SIM_BITS-1:0] o_value;
    logic [31:0]         idx_ext;

    assign cfg_ready = 1'b1;

    aigsim_front #(
        .MAX_OBJECTS (MAX_OBJECTS),
        .SIM_BITS    (SIM_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .fanin0_literal (fanin0_literal),
        .fanin1_literal (fanin1_literal),
        .pattern_word   (pattern_word),
        .last_in_round  (last_in_round),
        .push_valid     (push_valid),
        .push_full      (push_full),
        .push_ctl       (push_ctl),
        .push_idx       (push_idx),
        .push_var0      (push_var0),
        .push_var1      (push_var1),
        .push_pattern   (push_pattern)
    );

    assign push_data = {push_ctl, push_idx, push_var0, push_var1, push_pattern};

    aigsim_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .full       (push_full),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign {pop_ctl, pop_idx, pop_var0, pop_var1, pop_pattern} = pop_data;

    aigsim_back #(
        .MAX_OBJECTS (MAX_OBJECTS),
        .SIM_BITS    (SIM_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_ctl     (pop_ctl),
        .pop_idx     (pop_idx),
        .pop_var0    (pop_var0),
        .pop_var1    (pop_var1),
        .pop_pattern (pop_pattern),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .o_idx       (o_idx),
        .o_value     (o_value),
        .o_failed    (output_failed),
        .o_last      (round_end)
    );

    assign idx_ext      = 32'(o_idx);
    assign object_index = idx_ext[INDEX_W-1:0];
    assign node_value   = PORT_WORD_W'(o_value);

endmodule

`default_nettype wire

// ----- bench/aig_bit_parallel_simulator_tb.sv -----
`timescale 1ns / 1ps

module aig_bit_parallel_simulator_tb;
    import aigsim_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 80;
    localparam int STORE_DEPTH = 4096;
    localparam logic [PORT_WORD_W-1:0] ONES = {PORT_WORD_W{1'b1}};

    typedef struct packed {
        logic [INDEX_W-1:0]     idx;
        logic [PORT_WORD_W-1:0] val;
        logic                   fail;
        logic                   rend;
    } aig_result_t;

    typedef struct packed {
        logic [LIT_W-1:0]       f0;
        logic [LIT_W-1:0]       f1;
        logic [PORT_WORD_W-1:0] pat;
        logic                   ends;
        logic                   typed;
        aig_result_t            want;
    } dir_row_t;

    localparam dir_row_t DIR_ROWS [16] = '{
        '{13'd0,  13'd0, 64'd0,                  1'b0, 1'b1, '{12'd1,  64'd0, 1'b0, 1'b0}},
        '{13'd0,  13'd0, ONES,                   1'b0, 1'b1, '{12'd2,  ONES,  1'b0, 1'b0}},
        '{13'd0,  13'd2, 64'hA5A5_5A5A_0F0F_F0F0, 1'b0, 1'b1,
            '{12'd3, 64'hA5A5_5A5A_0F0F_F0F0, 1'b0, 1'b0}},
        '{13'd4,  13'd7, 64'd0,                  1'b0, 1'b0, '{12'd0,  64'd0, 1'b0, 1'b0}},
        '{13'd6,  13'd7, 64'd0,                  1'b0, 1'b1, '{12'd5,  64'd0, 1'b0, 1'b0}},
        '{13'd1,  13'd3, 64'd0,                  1'b0, 1'b1, '{12'd6,  ONES,  1'b0, 1'b0}},
        '{13'd2,  13'd0, 64'd0,                  1'b0, 1'b1, '{12'd7,  64'd0, 1'b0, 1'b0}},
        '{13'd13, 13'd0, 64'd0,                  1'b0, 1'b1, '{12'd8,  ONES,  1'b0, 1'b0}},
        '{13'd8,  13'd0, 64'd0,                  1'b0, 1'b0, '{12'd0,  64'd0, 1'b0, 1'b0}},
        '{13'd1,  13'd0, 64'd0,                  1'b1, 1'b1, '{12'd10, 64'd0, 1'b0, 1'b1}},
        '{13'd0,  13'd0, 64'h8000_0000_0000_0001, 1'b0, 1'b1,
            '{12'd1, 64'h8000_0000_0000_0001, 1'b0, 1'b0}},
        '{13'd3,  13'd0, ONES,                   1'b0, 1'b1,
            '{12'd2, 64'h8000_0000_0000_0001, 1'b1, 1'b0}},
        '{13'd2,  13'd0, 64'd0,                  1'b1, 1'b1,
            '{12'd3, 64'h8000_0000_0000_0001, 1'b0, 1'b1}},
        '{13'd0,  13'd0, 64'h0123_4567_89AB_CDEF, 1'b1, 1'b1,
            '{12'd1, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b1}},
        '{13'd3,  13'd0, 64'd0,                  1'b0, 1'b0, '{12'd0,  64'd0, 1'b0, 1'b0}},
        '{13'd19, 13'd16, 64'd0,                 1'b1, 1'b0, '{12'd0,  64'd0, 1'b0, 1'b0}}
    };

    logic                   clk            = 1'b0;
    logic                   rst_n          = 1'b0;
    logic                   cfg_valid      = 1'b0;
    logic                   cfg_ready;
    logic                   cfg_data       = 1'b0;
    logic                   in_valid       = 1'b0;
    logic                   in_stall;
    logic [LIT_W-1:0]       fanin0_literal = '0;
    logic [LIT_W-1:0]       fanin1_literal = '0;
    logic [PORT_WORD_W-1:0] pattern_word   = '0;
    logic                   last_in_round  = 1'b0;
    logic                   out_valid;
    logic                   out_stall      = 1'b0;
    logic [INDEX_W-1:0]     object_index;
    logic [PORT_WORD_W-1:0] node_value;
    logic                   output_failed;
    logic                   round_end;

    logic [PORT_WORD_W-1:0] value_mem [STORE_DEPTH];
    bit                     written_obj [STORE_DEPTH];
    logic [INDEX_W-1:0]     written_list [$];
    logic [INDEX_W-1:0]     next_idx = INDEX_W'(1);
    bit                     fail_seen = 1'b0;
    bit                     miter_on = 1'b0;
    aig_result_t            pending_results [$];
    int                     errors = 0;
    int                     send_pct = 0;
    int                     recv_pct = 0;
    bit                     hold_req = 1'b0;

    aig_bit_parallel_simulator u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .fanin0_literal (fanin0_literal),
        .fanin1_literal (fanin1_literal),
        .pattern_word   (pattern_word),
        .last_in_round  (last_in_round),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .object_index   (object_index),
        .node_value     (node_value),
        .output_failed  (output_failed),
        .round_end      (round_end)
    );

    always #6 clk = ~clk;

    function automatic logic [PORT_WORD_W-1:0] fetch_word(logic [LIT_W-1:0] lit, bit use_compl);
        logic [INDEX_W-1:0]     v;
        logic [PORT_WORD_W-1:0] w;
        v = lit[LIT_W-1:1];
        w = (v == 0) ? '0 : value_mem[v];
        if (use_compl && lit[0])
            w = ~w;
        return w;
    endfunction

    function automatic aig_result_t simulate_object(logic [LIT_W-1:0] a, logic [LIT_W-1:0] b,
                                                    logic [PORT_WORD_W-1:0] p, bit e);
        aig_result_t        r;
        aigsim_kind_t       k;
        logic [INDEX_W-1:0] idx;
        idx = next_idx;
        k = (a == 0) ? KIND_INPUT : (b == 0) ? KIND_OUTPUT : KIND_AND;
        r = '0;
        r.idx = idx;
        r.rend = e;
        case (k)
            KIND_INPUT:
                r.val = p;
            KIND_OUTPUT:
            begin
                r.val = fetch_word(a, 1'b0);
                if (miter_on && !fail_seen && fetch_word(a, 1'b1) != 0)
                begin
                    r.fail = 1'b1;
                    fail_seen = 1'b1;
                end
            end
            default:
                r.val = fetch_word(a, 1'b1) & fetch_word(b, 1'b1);
        endcase
        value_mem[idx] = r.val;
        if (!written_obj[idx])
        begin
            written_obj[idx] = 1'b1;
            written_list.push_back(idx);
        end
        if (e)
        begin
            next_idx = INDEX_W'(1);
            fail_seen = 1'b0;
        end
        else
        begin
            next_idx = idx + 1'b1;
            if (next_idx == 0)
                next_idx = INDEX_W'(1);
        end
        return r;
    endfunction

    function automatic logic [LIT_W-1:0] pick_lit();
        logic [INDEX_W-1:0] v;
        logic [LIT_W-1:0]   lit;
        int                 lo;
        if (next_idx > 1 && $urandom_range(99) < 80)
        begin
            lo = (next_idx > 8) ? int'(next_idx) - 8 : 1;
            v = INDEX_W'($urandom_range(int'(next_idx) - 1, lo));
        end
        else if ($urandom_range(9) == 0)
            v = '0;
        else
            v = written_list[$urandom_range(written_list.size() - 1)];
        lit = {v, 1'($urandom_range(1))};
        if (lit == 0)
            lit = LIT_W'(1);
        return lit;
    endfunction

    function automatic logic [PORT_WORD_W-1:0] random_pattern();
        case ($urandom_range(5))
            0: return '0;
            1: return ONES;
            2: return 64'd1 << $urandom_range(63);
            3: return ~(64'd1 << $urandom_range(63));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_obj(logic [LIT_W-1:0] a, logic [LIT_W-1:0] b,
                            logic [PORT_WORD_W-1:0] p, bit e, bit typed, aig_result_t want);
        aig_result_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        fanin0_literal <= a;
        fanin1_literal <= b;
        pattern_word   <= p;
        last_in_round  <= e;
        do
            @(posedge clk);
        while (in_stall);
        predicted = simulate_object(a, b, p, e);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic drop_valid();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_miter(bit on);
        wait_drained();
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= on;
        do
            @(posedge clk);
        while (!cfg_ready);
        miter_on = on;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_items(int count, bit one_round);
        int                     left;
        int                     roll;
        logic [LIT_W-1:0]       a;
        logic [LIT_W-1:0]       b;
        logic [PORT_WORD_W-1:0] p;
        bit                     e;
        aigsim_kind_t           k;
        left = one_round ? count : 0;
        for (int i = 0; i < count; i++)
        begin
            if (left == 0)
                left = ($urandom_range(9) == 0) ? $urandom_range(60, 17) : $urandom_range(16, 1);
            p = random_pattern();
            e = (left == 1);
            left--;
            if (!one_round && written_list.size() == STORE_DEPTH - 1 && $urandom_range(9) == 0)
            begin
                a = LIT_W'($urandom_range(8191));
                b = LIT_W'($urandom_range(8191));
                e = ($urandom_range(7) == 0);
            end
            else
            begin
                roll = $urandom_range(99);
                k = (next_idx <= 2 || roll < 35) ? KIND_INPUT :
                    (roll < 75) ? KIND_AND : KIND_OUTPUT;
                case (k)
                    KIND_INPUT:
                    begin
                        a = '0;
                        b = ($urandom_range(1) == 0) ? '0 : pick_lit();
                    end
                    KIND_AND:
                    begin
                        a = pick_lit();
                        b = pick_lit();
                    end
                    default:
                    begin
                        a = pick_lit();
                        b = '0;
                    end
                endcase
            end
            send_obj(a, b, p, e, 1'b0, '0);
        end
    endtask

    // receiver: random stalls, plus one long hold on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                repeat (HOLD_CYCLES)
                begin
                    out_stall <= 1'b1;
                    @(negedge clk);
                end
                hold_req = 1'b0;
            end
            out_stall <= ($urandom_range(99) < recv_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        aig_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected request result, object_index %0d node_value %h",
                         $time, object_index, node_value);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (object_index !== want.idx)
                begin
                    $display("%0t: object_index expected %0d got %0d", $time, want.idx,
                             object_index);
                    errors++;
                end
                if (node_value !== want.val)
                begin
                    $display("%0t: node_value expected %h got %h", $time, want.val, node_value);
                    errors++;
                end
                if (output_failed !== want.fail)
                begin
                    $display("%0t: output_failed expected %b got %b", $time, want.fail,
                             output_failed);
                    errors++;
                end
                if (round_end !== want.rend)
                begin
                    $display("%0t: round_end expected %b got %b", $time, want.rend, round_end);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_miter(1'b1);
        foreach (DIR_ROWS[i])
            send_obj(DIR_ROWS[i].f0, DIR_ROWS[i].f1, DIR_ROWS[i].pat, DIR_ROWS[i].ends,
                     DIR_ROWS[i].typed, DIR_ROWS[i].want);
        drop_valid();

        // one long round
        set_miter(1'b0);
        run_items(40, 1'b1);
        drop_valid();

        set_miter(1'b1);
        run_items(60, 1'b0);
        hold_req = 1'b1;
        run_items(165, 1'b0);
        drop_valid();

        send_pct = 85;
        set_miter(1'b0);
        run_items(225, 1'b0);
        drop_valid();

        send_pct = 0;
        recv_pct = 85;
        set_miter(1'b1);
        run_items(110, 1'b0);
        drop_valid();
        wait_drained();
        run_items(115, 1'b0);
        drop_valid();

        send_pct = 18;
        recv_pct = 18;
        set_miter(1'b0);
        run_items(225, 1'b0);
        drop_valid();

        wait_drained();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
